### hdl/trpr_pkg.sv
// ----------------------------------------------------------------------------
// trpr_pkg
// shared types and constants of the trie prefix root replacer
// ----------------------------------------------------------------------------
package trpr_pkg;

  localparam int NODE_COUNT = 1024;
  localparam int ALPHA_SIZE = 26;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int CNT_W      = NODE_W + 1;
  localparam int LETTER_W   = $clog2(ALPHA_SIZE);
  localparam int ENTRY_W    = NODE_W + 1;
  localparam int ROW_W      = ALPHA_SIZE * ENTRY_W;
  localparam int SYM_W      = 7;
  localparam int Q_DEPTH    = 2;
  localparam int QPTR_W     = $clog2(Q_DEPTH);
  localparam int QCNT_W     = $clog2(Q_DEPTH + 1);

  localparam logic [SYM_W-1:0] LETTER_BASE = 7'd97;
  localparam logic [SYM_W-1:0] LETTER_LAST = 7'd122;
  localparam logic [SYM_W-1:0] SPACE_CHAR  = 7'd32;

  localparam logic [1:0] KIND_DICT  = 2'd0;
  localparam logic [1:0] KIND_SENT  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic [1:0]          kind;
    logic [SYM_W-1:0]    symbol;
    logic                word_end;
    logic                is_letter;
    logic                is_space;
    logic [LETTER_W-1:0] letter;
  } item_t;

  typedef struct packed {
    logic             out_valid;
    logic [SYM_W-1:0] out_symbol;
    logic             sentence_done;
    logic [1:0]       status;
  } result_t;

endpackage

### hdl/trpr_ram.sv
// ----------------------------------------------------------------------------
// trpr_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module trpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/trpr_front.sv
// ----------------------------------------------------------------------------
// trpr_front
// accepts input requests, classifies the symbol and queues them
// ----------------------------------------------------------------------------
module trpr_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // symbol[6:0], zero pad
  input  logic                   in_tlast,
  input  logic [1:0]             in_tuser,   // kind[1:0]
  output logic                   q_valid,
  output trpr_pkg::item_t        q_item,
  input  logic                   q_pop
);

  trpr_pkg::item_t                    slot_r [trpr_pkg::Q_DEPTH];
  logic [trpr_pkg::QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [trpr_pkg::QPTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [trpr_pkg::QCNT_W-1:0]        count_r, count_nxt;
  trpr_pkg::item_t                    cls;
  logic [trpr_pkg::SYM_W-1:0]         sym;
  logic [trpr_pkg::SYM_W-1:0]         sym_off;
  logic                               push;

  assign sym     = in_tdata[trpr_pkg::SYM_W-1:0];
  assign sym_off = sym - trpr_pkg::LETTER_BASE;

  always_comb begin
    cls           = '0;
    cls.kind      = in_tuser;
    cls.symbol    = sym;
    cls.word_end  = in_tlast;
    cls.is_letter = (sym >= trpr_pkg::LETTER_BASE) && (sym <= trpr_pkg::LETTER_LAST);
    cls.is_space  = (sym == trpr_pkg::SPACE_CHAR);
    cls.letter    = cls.is_letter ? sym_off[trpr_pkg::LETTER_W-1:0] : '0;
  end

  assign in_tready = (count_r != trpr_pkg::QCNT_W'(trpr_pkg::Q_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != '0);
  assign q_item    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == trpr_pkg::QPTR_W'(trpr_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == trpr_pkg::QPTR_W'(trpr_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

endmodule

### hdl/trpr_back.sv
// ----------------------------------------------------------------------------
// trpr_back
// trie insert and walk engine over the node row memory, with output register
// ----------------------------------------------------------------------------
module trpr_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  trpr_pkg::item_t        q_item,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [7:0]             out_tdata,  // out_valid, out_symbol[6:0]
  output logic                   out_tlast,
  output logic [1:0]             out_tuser   // status[1:0]
);

  typedef enum logic [1:0] {S_INIT, S_IDLE, S_EXEC, S_ZERO} state_t;
  typedef enum logic [1:0] {M_WALK, M_SUPPRESS, M_ECHO} mode_t;

  state_t                              state_r, state_nxt;
  mode_t                               walk_mode_r, walk_mode_nxt;
  trpr_pkg::item_t                     cur_r, cur_nxt;
  logic [trpr_pkg::CNT_W-1:0]          nodes_used_r, nodes_used_nxt;
  logic [trpr_pkg::NODE_W-1:0]         ins_node_r, ins_node_nxt;
  logic [trpr_pkg::NODE_W-1:0]         ins_parent_r, ins_parent_nxt;
  logic [trpr_pkg::LETTER_W-1:0]       ins_letter_r, ins_letter_nxt;
  logic                                ins_failed_r, ins_failed_nxt;
  logic [trpr_pkg::NODE_W-1:0]         walk_node_r, walk_node_nxt;
  logic [trpr_pkg::NODE_W-1:0]         zero_node_r, zero_node_nxt;
  trpr_pkg::result_t                   out_r, out_nxt;
  logic                                out_vld_r, out_vld_nxt;

  logic                                ram_we, ram_re;
  logic [trpr_pkg::NODE_W-1:0]         ram_waddr, ram_raddr;
  logic [trpr_pkg::ROW_W-1:0]          ram_wdata, ram_rdata;

  logic                                commit;
  logic [trpr_pkg::ENTRY_W-1:0]        entry;
  logic [trpr_pkg::NODE_W-1:0]         child;
  logic                                child_end;
  logic [trpr_pkg::NODE_W-1:0]         dict_row;
  logic [trpr_pkg::NODE_W-1:0]         q_dict_row;
  logic [trpr_pkg::NODE_W-1:0]         new_node;
  trpr_pkg::result_t                   res;

  trpr_ram #(
    .WIDTH (trpr_pkg::ROW_W),
    .DEPTH (trpr_pkg::NODE_COUNT)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign commit     = (state_r == S_EXEC) && (!out_vld_r || out_tready);
  assign entry      = ram_rdata[int'(cur_r.letter) * trpr_pkg::ENTRY_W +: trpr_pkg::ENTRY_W];
  assign child      = entry[trpr_pkg::NODE_W-1:0];
  assign child_end  = entry[trpr_pkg::NODE_W];
  assign dict_row   = (cur_r.is_letter && !ins_failed_r) ? ins_node_r : ins_parent_r;
  assign q_dict_row = (q_item.is_letter && !ins_failed_r) ? ins_node_r : ins_parent_r;
  assign new_node   = nodes_used_r[trpr_pkg::NODE_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    walk_mode_nxt  = walk_mode_r;
    cur_nxt        = cur_r;
    nodes_used_nxt = nodes_used_r;
    ins_node_nxt   = ins_node_r;
    ins_parent_nxt = ins_parent_r;
    ins_letter_nxt = ins_letter_r;
    ins_failed_nxt = ins_failed_r;
    walk_node_nxt  = walk_node_r;
    zero_node_nxt  = zero_node_r;
    out_nxt        = out_r;
    q_pop          = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = walk_node_r;
    ram_we         = 1'b0;
    ram_waddr      = dict_row;
    ram_wdata      = ram_rdata;
    res            = '0;

    case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '0;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cur_nxt   = q_item;
          ram_re    = 1'b1;
          state_nxt = S_EXEC;
          case (q_item.kind)
            trpr_pkg::KIND_SENT: ram_raddr = walk_node_r;
            trpr_pkg::KIND_DICT: ram_raddr = q_dict_row;
            default:             ram_raddr = '0;
          endcase
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_nxt = S_IDLE;
          case (cur_r.kind)
            trpr_pkg::KIND_CLEAR: begin
              ram_we         = 1'b1;
              ram_waddr      = '0;
              ram_wdata      = '0;
              nodes_used_nxt = trpr_pkg::CNT_W'(1);
              ins_node_nxt   = '0;
              ins_parent_nxt = '0;
              ins_letter_nxt = '0;
              ins_failed_nxt = 1'b0;
              walk_node_nxt  = '0;
              walk_mode_nxt  = M_WALK;
            end
            trpr_pkg::KIND_DICT: begin
              if (!cur_r.is_letter) begin
                res.status = trpr_pkg::ST_BAD;
              end else if (ins_failed_r) begin
                res.status = trpr_pkg::ST_FULL;
              end else if (child == '0) begin
                if (nodes_used_r >= trpr_pkg::CNT_W'(trpr_pkg::NODE_COUNT)) begin
                  ins_failed_nxt = 1'b1;
                  res.status     = trpr_pkg::ST_FULL;
                end else begin
                  ram_we = 1'b1;
                  ram_wdata[int'(cur_r.letter) * trpr_pkg::ENTRY_W +: trpr_pkg::NODE_W] =
                    new_node;
                  nodes_used_nxt = nodes_used_r + trpr_pkg::CNT_W'(1);
                  ins_node_nxt   = new_node;
                  ins_parent_nxt = ins_node_r;
                  ins_letter_nxt = cur_r.letter;
                  zero_node_nxt  = new_node;
                  state_nxt      = S_ZERO;
                end
              end else begin
                ins_node_nxt   = child;
                ins_parent_nxt = ins_node_r;
                ins_letter_nxt = cur_r.letter;
              end
              if (cur_r.word_end) begin
                if (!ins_failed_nxt && (ins_node_nxt != '0)) begin
                  ram_we = 1'b1;
                  ram_wdata[int'(ins_letter_nxt) * trpr_pkg::ENTRY_W + trpr_pkg::NODE_W] =
                    1'b1;
                end
                ins_node_nxt   = '0;
                ins_failed_nxt = 1'b0;
              end
            end
            trpr_pkg::KIND_SENT: begin
              if (cur_r.is_space) begin
                res.out_valid  = 1'b1;
                res.out_symbol = cur_r.symbol;
                walk_node_nxt  = '0;
                walk_mode_nxt  = M_WALK;
              end else begin
                if (!cur_r.is_letter) begin
                  res.status = trpr_pkg::ST_BAD;
                end
                case (walk_mode_r)
                  M_WALK: begin
                    res.out_valid  = 1'b1;
                    res.out_symbol = cur_r.symbol;
                    if (!cur_r.is_letter || (child == '0)) begin
                      walk_mode_nxt = M_ECHO;
                    end else begin
                      walk_node_nxt = child;
                      if (child_end) begin
                        walk_mode_nxt = M_SUPPRESS;
                      end
                    end
                  end
                  M_ECHO: begin
                    res.out_valid  = 1'b1;
                    res.out_symbol = cur_r.symbol;
                  end
                  default: begin
                    res.out_valid = 1'b0;
                  end
                endcase
              end
              if (cur_r.word_end) begin
                res.sentence_done = 1'b1;
                walk_node_nxt     = '0;
                walk_mode_nxt     = M_WALK;
              end
            end
            default: begin
              res = '0;
            end
          endcase
          out_nxt = res;
        end
      end
      S_ZERO: begin
        ram_we    = 1'b1;
        ram_waddr = zero_node_r;
        ram_wdata = '0;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (commit) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      walk_mode_r  <= M_WALK;
      nodes_used_r <= trpr_pkg::CNT_W'(1);
      ins_node_r   <= '0;
      ins_parent_r <= '0;
      ins_letter_r <= '0;
      ins_failed_r <= 1'b0;
      walk_node_r  <= '0;
      out_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      walk_mode_r  <= walk_mode_nxt;
      nodes_used_r <= nodes_used_nxt;
      ins_node_r   <= ins_node_nxt;
      ins_parent_r <= ins_parent_nxt;
      ins_letter_r <= ins_letter_nxt;
      ins_failed_r <= ins_failed_nxt;
      walk_node_r  <= walk_node_nxt;
      out_vld_r    <= out_vld_nxt;
    end
    cur_r       <= cur_nxt;
    zero_node_r <= zero_node_nxt;
    out_r       <= out_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_r.out_symbol, out_r.out_valid};
  assign out_tlast  = out_r.sentence_done;
  assign out_tuser  = out_r.status;

  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    (nodes_used_r >= trpr_pkg::CNT_W'(1)) &&
    (nodes_used_r <= trpr_pkg::CNT_W'(trpr_pkg::NODE_COUNT)))
    else $error("node pool count out of range");

  a_walk_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, walk_node_r} < nodes_used_r) && ({1'b0, ins_node_r} < nodes_used_r))
    else $error("walk or insert position on an unallocated node");

  a_pop_exec: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == S_EXEC))
    else $error("popped request not executed");

  a_zero_after_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ZERO) |-> (zero_node_r == ins_node_r) || $past(cur_r.word_end))
    else $error("row zeroing not on the new node");

  a_no_rw: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("row memory read and write in one cycle");

endmodule

### hdl/trie_prefix_root_replacer_unit.sv
// ----------------------------------------------------------------------------
// trie_prefix_root_replacer_unit
// replaces each sentence word by its shortest dictionary root from a trie
// ----------------------------------------------------------------------------
// in channel: tuser kind (dictionary letter, sentence character, clear),
//   tdata symbol, tlast marks the last letter of a root or of a sentence
// out channel: one result per request; tdata out_valid and out_symbol,
//   tlast sentence done, tuser status (ok, pool full, bad symbol)
// requests pass a two entry queue into the trie engine, which reads one
//   node row per request from the row memory and writes it back for
//   dictionary letters; the engine takes a new request only once the last
//   one is done, and one that takes a new node also zeroes that node's row
//   in the S_ZERO state before the engine returns to idle
// reset: control cleared, the root row is zeroed in the S_INIT state; requests
//   are queued meanwhile; a clear request zeroes the root row and frees nodes
// a stalled receiver holds the result in the output register; the queue keeps
//   accepting until full, then in_tready drops
// ----------------------------------------------------------------------------
module trie_prefix_root_replacer_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // symbol[6:0], zero pad
  input  logic       in_tlast,
  input  logic [1:0] in_tuser,   // kind[1:0]
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_valid, out_symbol[6:0]
  output logic       out_tlast,
  output logic [1:0] out_tuser   // status[1:0]
);

  logic            q_valid;
  logic            q_pop;
  trpr_pkg::item_t q_item;

  trpr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  trpr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
